/* hw/rtl/linear_probe_hash_table_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the hash table core
// Shorthand for clocked implication checks on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Sizes, codes and helpers for the linear probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_SIZE = 16;

	localparam int KEY_W  = 16;
	localparam int VAL_W  = 16;
	localparam int SLOT_W = 4;
	localparam int ECNT_W = 5;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int ENT_W = KEY_W + VAL_W;

	localparam int SLOT_PAD_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int ECNT_PAD_W = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam idx_t LAST_IDX = idx_t'(TABLE_SIZE - 1);

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_PRESENT  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PROBE
	} state_t;

	function automatic logic [SLOT_W-1:0] to_slot(idx_t i);
		logic [SLOT_PAD_W-1:0] p;
		p = SLOT_PAD_W'(i);
		return p[SLOT_W-1:0];
	endfunction

	function automatic logic [ECNT_W-1:0] to_ecnt(cnt_t c);
		logic [ECNT_PAD_W-1:0] p;
		p = ECNT_PAD_W'(c);
		return p[ECNT_W-1:0];
	endfunction

endpackage

/* hw/rtl/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing key/value table with linear probing and full detection.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; exactly one
// result word follows, shown for a single cycle with done high, and the
// receiver must take it then as it cannot stall the core. Every request first
// scans the slots one per cycle through the single read port of the entry RAM,
// which has a registered read, with one shared key compare: a lookup or a key
// already present returns its word from that scan. An insert of a new key then
// probes the valid bits one slot per cycle from its home slot (the low key
// bits, as TABLE_SIZE is a power of two), up to TABLE_SIZE slots. busy is low
// in the done cycle, so the next word can be taken then. Valid bits are flops
// cleared by reset, so the table is empty at once and no clearing pass runs.
`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [lpht_pkg::KEY_W-1:0]  key,
	input  logic [lpht_pkg::VAL_W-1:0]  value_in,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [lpht_pkg::VAL_W-1:0]  value_out,
	output logic [lpht_pkg::SLOT_W-1:0] slot,
	output logic [lpht_pkg::ECNT_W-1:0] entry_count
);

	import lpht_pkg::*;

	state_t                 state_q, state_d;
	logic                   req_q;
	logic [KEY_W-1:0]       key_q;
	logic [VAL_W-1:0]       val_q;
	idx_t                   idx_q, idx_d;
	logic                   issued_all_q, issued_all_d;
	logic                   rd_vld_s1, rd_vld_d;
	idx_t                   rd_idx_s1;
	idx_t                   probe_n_q, probe_n_d;
	logic [TABLE_SIZE-1:0]  valid_q;
	cnt_t                   count_q;
	logic                   done_q;
	status_t                status_q, fin_status;
	logic [VAL_W-1:0]       value_out_q, fin_val;
	idx_t                   fin_slot;
	logic [SLOT_W-1:0]      slot_q;
	logic                   fin, we, accept;
	logic [ENT_W-1:0]       rdata;
	logic [KEY_W-1:0]       rd_key;
	logic [VAL_W-1:0]       rd_val;
	logic                   match;

	lpht_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata ({key_q, val_q}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rd_key = rdata[ENT_W-1:VAL_W];
	assign rd_val = rdata[VAL_W-1:0];
	assign match  = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_key == key_q);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		issued_all_d = issued_all_q;
		rd_vld_d     = 1'b0;
		probe_n_d    = probe_n_q;
		fin          = 1'b0;
		fin_status   = ST_MISS;
		fin_val      = '0;
		fin_slot     = '0;
		we           = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d      = S_SCAN;
					idx_d        = '0;
					issued_all_d = 1'b0;
				end
			end
			S_SCAN: begin
				rd_vld_d = !issued_all_q;
				if (!issued_all_q) begin
					if (idx_q == LAST_IDX) begin
						issued_all_d = 1'b1;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				if (match) begin
					fin      = 1'b1;
					state_d  = S_IDLE;
					fin_slot = rd_idx_s1;
					if (req_q) begin
						fin_status = ST_PRESENT;
					end else begin
						fin_status = ST_HIT;
						fin_val    = rd_val;
					end
				end else if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
					if (req_q) begin
						// home slot is key mod TABLE_SIZE, the low key bits
						state_d   = S_PROBE;
						idx_d     = key_q[IDX_W-1:0];
						probe_n_d = '0;
					end else begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_PROBE: begin
				if (!valid_q[idx_q]) begin
					we         = 1'b1;
					fin        = 1'b1;
					fin_status = ST_INSERTED;
					fin_slot   = idx_q;
					state_d    = S_IDLE;
				end else if (probe_n_q == LAST_IDX) begin
					fin        = 1'b1;
					fin_status = ST_FULL;
					state_d    = S_IDLE;
				end else begin
					idx_d     = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
					probe_n_d = probe_n_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_vld_d;
			done_q    <= fin;
			if (we) begin
				valid_q[idx_q] <= 1'b1;
				count_q        <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			key_q <= key;
			val_q <= value_in;
		end
		idx_q        <= idx_d;
		issued_all_q <= issued_all_d;
		rd_idx_s1    <= idx_q;
		probe_n_q    <= probe_n_d;
		if (fin) begin
			status_q    <= fin_status;
			value_out_q <= fin_val;
			slot_q      <= to_slot(fin_slot);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign slot        = slot_q;
	assign entry_count = to_ecnt(count_q);

	`LPHT_ASSERT_IMP(a_count_matches_valid, 1'b1, $countones(valid_q) == count_q,
		"entry count disagrees with valid bits")
	`LPHT_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy,
		"accepted word did not start work")
	`LPHT_ASSERT_IMP(a_insert_bumps_count, done && (status_q == ST_INSERTED),
		count_q == $past(count_q) + 1'b1, "insert did not bump entry count")
	`LPHT_ASSERT_IMP(a_full_only_when_full, done && (status_q == ST_FULL),
		count_q == TABLE_SIZE, "full reported with free slots")
	`LPHT_ASSERT_IMP(a_done_when_idle, done, !busy,
		"result word shown while still busy")

endmodule

/* test/tb_linear_probe_hash_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_core
// Sends lookup and insert words to the hash table core and keeps a shadow copy
// of the table. Each result word is checked field by field against the
// prediction. The table is taken through empty, collisions and wrap-around,
// partial fill under random traffic, full, and a long random run once full.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_core;
	import lpht_pkg::*;

	localparam logic REQ_LOOKUP   = 1'b0;
	localparam logic REQ_INSERT   = 1'b1;
	localparam int   MAX_LATENCY  = 2 * TABLE_SIZE + 2;
	localparam int   REPORT_LIMIT = 10;

	typedef struct packed {
		status_t           st;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] slot;
		logic [ECNT_W-1:0] count;
	} ht_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              req_type;
	logic [KEY_W-1:0]  key;
	logic [VAL_W-1:0]  value_in;
	logic              done;
	logic [2:0]        status;
	logic [VAL_W-1:0]  value_out;
	logic [SLOT_W-1:0] slot;
	logic [ECNT_W-1:0] entry_count;

	// shadow table
	bit               tbl_valid [TABLE_SIZE];
	logic [KEY_W-1:0] tbl_key   [TABLE_SIZE];
	logic [VAL_W-1:0] tbl_val   [TABLE_SIZE];
	int               tbl_count;

	ht_result_t predicted_replies[$];
	ht_result_t want;
	int         err_count;
	int         items_sent;
	int         results_seen;
	int         outcome_tally [5];

	// stimulus side view of which keys went in
	bit               key_seen [bit [KEY_W-1:0]];
	logic [KEY_W-1:0] stored_keys[$];
	bit               idle_on;

	linear_probe_hash_table_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.key         (key),
		.value_in    (value_in),
		.done        (done),
		.status      (status),
		.value_out   (value_out),
		.slot        (slot),
		.entry_count (entry_count)
	);

	always #5 clk = ~clk;

	function automatic void flag_error(string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT) begin
			$display("%0t ERROR: %s", $realtime, msg);
		end
	endfunction

	// applies one request to the shadow table and returns the word it should give
	function automatic ht_result_t predict_table_op(logic rt, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		ht_result_t r;
		int         hit_idx;
		int         pos;
		int         i;
		hit_idx = -1;
		r.value = '0;
		r.slot  = '0;
		for (i = 0; i < TABLE_SIZE; i++) begin
			if (hit_idx < 0 && tbl_valid[i] && tbl_key[i] == k) begin
				hit_idx = i;
			end
		end
		if (rt == REQ_LOOKUP) begin
			if (hit_idx >= 0) begin
				r.st    = ST_HIT;
				r.value = tbl_val[hit_idx];
				r.slot  = SLOT_W'(hit_idx);
			end else begin
				r.st = ST_MISS;
			end
		end else if (hit_idx >= 0) begin
			r.st   = ST_PRESENT;
			r.slot = SLOT_W'(hit_idx);
		end else begin
			r.st = ST_FULL;
			pos  = int'(k) % TABLE_SIZE;
			for (i = 0; i < TABLE_SIZE && r.st == ST_FULL; i++) begin
				if (!tbl_valid[pos]) begin
					tbl_valid[pos] = 1'b1;
					tbl_key[pos]   = k;
					tbl_val[pos]   = v;
					tbl_count++;
					r.st   = ST_INSERTED;
					r.slot = SLOT_W'(pos);
				end else begin
					pos = (pos + 1) % TABLE_SIZE;
				end
			end
		end
		r.count = ECNT_W'(tbl_count);
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			predicted_replies.push_back(predict_table_op(req_type, key, value_in));
		end
		if (arst_n && done) begin
			results_seen++;
			if (predicted_replies.size() == 0) begin
				flag_error("result word with nothing outstanding");
			end else begin
				want = predicted_replies.pop_front();
				outcome_tally[int'(want.st)]++;
				if (status !== want.st)
					flag_error($sformatf("status exp %0d got %0d", want.st, status));
				if (value_out !== want.value)
					flag_error($sformatf("value_out exp %h got %h", want.value, value_out));
				if (slot !== want.slot)
					flag_error($sformatf("slot exp %0d got %0d", want.slot, slot));
				if (entry_count !== want.count)
					flag_error($sformatf("entry_count exp %0d got %0d",
						want.count, entry_count));
			end
		end
	end

	task automatic send_req(input logic rt, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		if (idle_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= rt;
		key      <= k;
		value_in <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		if (rt == REQ_INSERT && !key_seen.exists(k) && stored_keys.size() < TABLE_SIZE) begin
			key_seen[k] = 1'b1;
			stored_keys.push_back(k);
		end
	endtask

	// unused key; half of them land on a crowded home slot to force probing
	task automatic fresh_key(output logic [KEY_W-1:0] k);
		do begin
			k = KEY_W'($urandom);
			if ($urandom_range(1))
				k[3:0] = $urandom_range(1) ? 4'hF : 4'($urandom_range(2));
		end while (key_seen.exists(k));
	endtask

	function automatic logic [KEY_W-1:0] known_key();
		return stored_keys[$urandom_range(stored_keys.size() - 1)];
	endfunction

	task automatic random_item(input int new_pct);
		logic [KEY_W-1:0] k;
		int               r;
		r = $urandom_range(99);
		k = KEY_W'($urandom);
		if (r < new_pct && stored_keys.size() < TABLE_SIZE) begin
			fresh_key(k);
			send_req(REQ_INSERT, k, VAL_W'($urandom));
		end else if (r < 45 && stored_keys.size() > 0) begin
			send_req(REQ_LOOKUP, known_key(), VAL_W'($urandom));
		end else if (r < 60 && stored_keys.size() > 0) begin
			send_req(REQ_INSERT, known_key(), VAL_W'($urandom));
		end else if (r < 75 && stored_keys.size() > 0) begin
			// near miss: one key bit flipped
			send_req(REQ_LOOKUP, known_key() ^ (KEY_W'(1) << $urandom_range(KEY_W - 1)),
				VAL_W'($urandom));
		end else if (r < 90 || stored_keys.size() < TABLE_SIZE) begin
			send_req(REQ_LOOKUP, k, VAL_W'($urandom));
		end else begin
			send_req(REQ_INSERT, k, VAL_W'($urandom));
		end
	endtask

	task automatic test_empty_table();
		send_req(REQ_LOOKUP, 16'h0000, 16'hFFFF);
		send_req(REQ_LOOKUP, 16'hFFFF, 16'h0000);
	endtask

	task automatic test_collision_and_wrap();
		send_req(REQ_INSERT, 16'hFFFF, 16'hFFFF);
		send_req(REQ_INSERT, 16'h000F, 16'h0000);	// home slot taken, wraps to 0
		send_req(REQ_INSERT, 16'h0000, 16'hA5A5);
		send_req(REQ_INSERT, 16'hFFFF, 16'h1234);	// already there, value kept
		send_req(REQ_INSERT, 16'h8001, 16'h5A5A);
		send_req(REQ_LOOKUP, 16'hFFFF, 16'h0000);
		send_req(REQ_LOOKUP, 16'h000F, 16'hFFFF);
		send_req(REQ_LOOKUP, 16'h0000, 16'h0000);
		send_req(REQ_LOOKUP, 16'h8001, 16'h0000);
		send_req(REQ_LOOKUP, 16'h8000, 16'h0000);
		send_req(REQ_LOOKUP, 16'h7FFF, 16'hFFFF);
	endtask

	task automatic test_partial_table_random();
		repeat (280) random_item(6);
	endtask

	task automatic test_table_full();
		logic [KEY_W-1:0] k;
		idle_on = 1'b0;
		while (stored_keys.size() < TABLE_SIZE) begin
			fresh_key(k);
			send_req(REQ_INSERT, k, VAL_W'($urandom));
		end
		repeat (4) begin
			fresh_key(k);
			send_req(REQ_INSERT, k, VAL_W'($urandom));
		end
		send_req(REQ_INSERT, 16'hFFFF, 16'h0000);
		foreach (stored_keys[i]) send_req(REQ_LOOKUP, stored_keys[i], VAL_W'($urandom));
	endtask

	task automatic test_full_table_random();
		repeat (120) random_item(0);
		idle_on = 1'b1;
		repeat (300) random_item(0);
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		req_type <= REQ_LOOKUP;
		key      <= '0;
		value_in <= '0;
		idle_on   = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_collision_and_wrap();
		test_partial_table_random();
		test_table_full();
		test_full_table_random();

		start <= 1'b0;
		while (results_seen < items_sent) @(posedge clk);
		repeat (MAX_LATENCY + 8) @(posedge clk);
		if (predicted_replies.size() != 0)
			flag_error($sformatf("%0d result words never arrived", predicted_replies.size()));

		$display("Checked %0d requests: empty table, probe collisions with wrap, fill, full.",
			items_sent);
		$display("Outcomes seen: hit %0d, miss %0d, inserted %0d, present %0d, full %0d",
			outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
			outcome_tally[4]);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/linear_probe_hash_table_core.sv
test/tb_linear_probe_hash_table_core.sv
